// File: sv/text_console_writer_assert.svh
// Assertion macros for the console writer RTL
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Condition must hold in the same cycle as the trigger
`define TCW_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition must hold in the cycle after the trigger
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/tcw_pkg.sv
// Shared types and codes for the text console writer
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

	localparam logic [1:0] REQ_PUT   = 2'd0;
	localparam logic [1:0] REQ_CLEAR = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
	localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
	localparam logic [7:0] CHAR_BLANK     = 8'h20;
	localparam logic [7:0] RESET_ATTR     = 8'h0F;

	typedef struct packed {
		logic [7:0] attr;
		logic [7:0] ch;
	} cell_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCROLL,
		ST_BLANK,
		ST_FINISH
	} tcw_state_t;

endpackage

`default_nettype wire

// File: sv/tcw_channels.sv
// Handshake channel interfaces: request, response and configuration
`timescale 1ns / 1ps
`default_nettype none

interface tcw_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [7:0]  char_code;
	logic [10:0] cell_index;

	modport source (output valid, req_type, char_code, cell_index, input ready);
	modport sink   (input valid, req_type, char_code, cell_index, output ready);
endinterface

interface tcw_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_char;
	logic [7:0] read_attribute;
	logic [6:0] cursor_column;
	logic [4:0] cursor_row;

	modport source (output valid, read_char, read_attribute, cursor_column, cursor_row,
		input ready);
	modport sink   (input valid, read_char, read_attribute, cursor_column, cursor_row,
		output ready);
endinterface

interface tcw_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] fill_attribute;

	modport source (output valid, fill_attribute, input ready);
	modport sink   (input valid, fill_attribute, output ready);
endinterface

`default_nettype wire

// File: sv/tcw_screen_ram.sv
// Screen cell memory: one write port, one read port, registered read data
`timescale 1ns / 1ps
`default_nettype none

module tcw_screen_ram #(
	parameter int AW    = 11,
	parameter int DEPTH = 2000
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire tcw_pkg::cell_t wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output tcw_pkg::cell_t     rd_data
);

	tcw_pkg::cell_t mem [DEPTH];
	tcw_pkg::cell_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read data holds until the next read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// File: sv/tcw_ctrl.sv
// Request sequencer: cursor, scroll/clear sweeps and response register
`timescale 1ns / 1ps
`default_nettype none

`include "text_console_writer_assert.svh"

module tcw_ctrl #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25,
	parameter int AW      = 11
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	tcw_req_if.sink            req,
	tcw_rsp_if.source          rsp,
	tcw_cfg_if.sink            cfg,
	output logic               ram_we,
	output logic [AW-1:0]      ram_waddr,
	output tcw_pkg::cell_t     ram_wdata,
	output logic               ram_re,
	output logic [AW-1:0]      ram_raddr,
	input  wire tcw_pkg::cell_t ram_rdata
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int CW    = $clog2(COLUMNS);
	localparam int RW    = $clog2(ROWS);

	localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
	localparam logic [AW-1:0] MOVE_END  = AW'((ROWS - 1) * COLUMNS);
	localparam logic [AW-1:0] COL_STEP  = AW'(COLUMNS);
	localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
	localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);

	tcw_pkg::tcw_state_t state_q, state_d;
	logic [CW-1:0] col_q, col_d;
	logic [RW-1:0] row_q, row_d;
	logic [AW-1:0] ptr_q, ptr_d;
	logic [7:0]    fill_attr_q;
	logic          rd_hit_q, rd_hit_d;

	logic          copy_vld_s1, copy_vld_d;
	logic [AW-1:0] copy_addr_s1;

	logic          out_vld_q;
	logic [7:0]    out_char_q, out_attr_q;
	logic [6:0]    out_col_q;
	logic [4:0]    out_row_q;
	logic          out_load;

	logic          req_ready;
	logic          fsm_we;
	logic [AW-1:0] fsm_addr;
	tcw_pkg::cell_t fsm_data;
	logic [AW-1:0] row_base, cur_addr;
	logic          in_range;

	assign row_base = AW'(row_q) * COL_STEP;
	assign cur_addr = row_base + AW'(col_q);
	assign in_range = 32'(req.cell_index) < 32'(CELLS);

	always_comb begin
		state_d    = state_q;
		col_d      = col_q;
		row_d      = row_q;
		ptr_d      = ptr_q;
		rd_hit_d   = rd_hit_q;
		copy_vld_d = 1'b0;
		out_load   = 1'b0;
		req_ready  = 1'b0;
		fsm_we     = 1'b0;
		fsm_addr   = cur_addr;
		fsm_data   = '{attr: fill_attr_q, ch: tcw_pkg::CHAR_BLANK};
		ram_re     = 1'b0;
		ram_raddr  = AW'(req.cell_index);
		case (state_q)
			tcw_pkg::ST_INIT: begin
				// power-up fill uses the reset attribute, not the register
				fsm_we        = 1'b1;
				fsm_addr      = ptr_q;
				fsm_data.attr = tcw_pkg::RESET_ATTR;
				if (ptr_q == LAST_CELL) begin
					ptr_d   = '0;
					state_d = tcw_pkg::ST_IDLE;
				end else begin
					ptr_d = ptr_q + 1'b1;
				end
			end
			tcw_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req.valid) begin
					rd_hit_d = 1'b0;
					state_d  = tcw_pkg::ST_FINISH;
					case (req.req_type)
						tcw_pkg::REQ_PUT: begin
							if (req.char_code == tcw_pkg::CHAR_NEWLINE) begin
								col_d = '0;
								if (row_q == ROW_LAST) begin
									ptr_d   = '0;
									state_d = tcw_pkg::ST_SCROLL;
								end else begin
									row_d = row_q + 1'b1;
								end
							end else if (req.char_code == tcw_pkg::CHAR_BACKSPACE) begin
								if (col_q != '0) begin
									col_d    = col_q - 1'b1;
									fsm_we   = 1'b1;
									fsm_addr = cur_addr - 1'b1;
								end
							end else begin
								fsm_we      = 1'b1;
								fsm_data.ch = req.char_code;
								if (col_q == COL_LAST) begin
									col_d = '0;
									if (row_q == ROW_LAST) begin
										ptr_d   = '0;
										state_d = tcw_pkg::ST_SCROLL;
									end else begin
										row_d = row_q + 1'b1;
									end
								end else begin
									col_d = col_q + 1'b1;
								end
							end
						end
						tcw_pkg::REQ_CLEAR: begin
							col_d   = '0;
							row_d   = '0;
							ptr_d   = '0;
							state_d = tcw_pkg::ST_BLANK;
						end
						tcw_pkg::REQ_READ: begin
							ram_re   = 1'b1;
							rd_hit_d = in_range;
						end
						default: begin
						end
					endcase
				end
			end
			tcw_pkg::ST_SCROLL: begin
				// read one row down; the copy write lands in the next cycle via _s1
				if (ptr_q == MOVE_END) begin
					state_d = tcw_pkg::ST_BLANK;
				end else begin
					ram_re     = 1'b1;
					ram_raddr  = ptr_q + COL_STEP;
					copy_vld_d = 1'b1;
					ptr_d      = ptr_q + 1'b1;
				end
			end
			tcw_pkg::ST_BLANK: begin
				fsm_we   = 1'b1;
				fsm_addr = ptr_q;
				if (ptr_q == LAST_CELL) begin
					state_d = tcw_pkg::ST_FINISH;
				end else begin
					ptr_d = ptr_q + 1'b1;
				end
			end
			tcw_pkg::ST_FINISH: begin
				if (!out_vld_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = tcw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tcw_pkg::ST_INIT;
			end
		endcase
	end

	always_comb begin
		if (copy_vld_s1) begin
			ram_we    = 1'b1;
			ram_waddr = copy_addr_s1;
			ram_wdata = ram_rdata;
		end else begin
			ram_we    = fsm_we;
			ram_waddr = fsm_addr;
			ram_wdata = fsm_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tcw_pkg::ST_INIT;
			col_q       <= '0;
			row_q       <= '0;
			ptr_q       <= '0;
			fill_attr_q <= tcw_pkg::RESET_ATTR;
			copy_vld_s1 <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			state_q     <= state_d;
			col_q       <= col_d;
			row_q       <= row_d;
			ptr_q       <= ptr_d;
			copy_vld_s1 <= copy_vld_d;
			out_vld_q   <= out_load | (out_vld_q & ~rsp.ready);
			if (cfg.valid) begin
				fill_attr_q <= cfg.fill_attribute;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_hit_q     <= rd_hit_d;
		copy_addr_s1 <= ptr_q;
		if (out_load) begin
			out_char_q <= rd_hit_q ? ram_rdata.ch : 8'h00;
			out_attr_q <= rd_hit_q ? ram_rdata.attr : 8'h00;
			out_col_q  <= 7'(col_q);
			out_row_q  <= 5'(row_q);
		end
	end

	assign req.ready          = req_ready;
	assign cfg.ready          = 1'b1;
	assign rsp.valid          = out_vld_q;
	assign rsp.read_char      = out_char_q;
	assign rsp.read_attribute = out_attr_q;
	assign rsp.cursor_column  = out_col_q;
	assign rsp.cursor_row     = out_row_q;

	`TCW_ASSERT_NOW(a_cursor_on_screen, 1'b1,
		(int'(col_q) < COLUMNS) && (int'(row_q) < ROWS), "cursor off screen")
	`TCW_ASSERT_NOW(a_scroll_cursor_home, state_q == tcw_pkg::ST_SCROLL,
		(row_q == ROW_LAST) && (col_q == '0), "cursor not at bottom row start during scroll")
	`TCW_ASSERT_NOW(a_copy_above_bottom, copy_vld_s1, copy_addr_s1 < MOVE_END,
		"scroll copy writes into bottom row")
	`TCW_ASSERT_NOW(a_no_accept_in_copy, copy_vld_s1, !req_ready,
		"request taken while scroll copy in flight")
	`TCW_ASSERT_NEXT(a_read_to_finish,
		req_ready && req.valid && (req.req_type == tcw_pkg::REQ_READ),
		state_q == tcw_pkg::ST_FINISH, "read did not go straight to response")

endmodule

`default_nettype wire

// File: sv/text_console_writer.sv
// Text console writer: screen cell memory, cursor and request sequencer
// After reset the block sweeps the whole screen to blanks before it takes its first
// request; configuration writes are taken throughout. Put-char without scroll and read
// transfer the request and touch the memory in ST_IDLE, then load the response register
// in ST_FINISH once the output is free. A clear walks every cell through the single
// memory write port; a put that scrolls copies every row up one cell a cycle and blanks
// the bottom row. A new request may transfer while the previous response still waits on
// the output.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire logic clk,
	input  wire logic arst_n,
	tcw_req_if.sink   req,
	tcw_rsp_if.source rsp,
	tcw_cfg_if.sink   cfg
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);

	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	tcw_pkg::cell_t ram_wdata;
	logic           ram_re;
	logic [AW-1:0]  ram_raddr;
	tcw_pkg::cell_t ram_rdata;

	tcw_ctrl #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS),
		.AW     (AW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.cfg      (cfg),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata)
	);

	tcw_screen_ram #(
		.AW   (AW),
		.DEPTH(CELLS)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_en  (ram_re),
		.rd_addr(ram_raddr),
		.rd_data(ram_rdata)
	);

endmodule

`default_nettype wire

// File: verif/tb_text_console_writer.sv
// Testbench for text_console_writer: directed table and random bursts against a predictor
`timescale 1ns / 1ps

module tb_text_console_writer;

	localparam int COLS  = 80;
	localparam int ROWS  = 25;
	localparam int CELLS = COLS * ROWS;
	localparam int ITEMS_PER_PHASE = 100;
	localparam int PHASES = 5;
	localparam int WATCHDOG_LIMIT = 10000;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	localparam logic [7:0] CH_NL    = tcw_pkg::CHAR_NEWLINE;
	localparam logic [7:0] CH_BS    = tcw_pkg::CHAR_BACKSPACE;
	localparam logic [7:0] CH_SP    = tcw_pkg::CHAR_BLANK;
	localparam logic [7:0] ATTR_RST = tcw_pkg::RESET_ATTR;

	typedef struct packed {
		logic [7:0] ch;
		logic [7:0] attr;
		logic [6:0] col;
		logic [4:0] row;
	} report_t;

	typedef struct packed {
		logic    given;
		report_t rpt;
	} typed_report_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  code;
		logic [10:0] idx;
		logic        given;
		report_t     rpt;
	} stim_row_t;

	localparam int N_DIRECTED = 24;
	localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
		'{tcw_pkg::REQ_READ,  8'h00, 11'd0,    1'b1, '{CH_SP, ATTR_RST, 7'd0, 5'd0}},
		'{tcw_pkg::REQ_READ,  8'h00, 11'd1999, 1'b1, '{CH_SP, ATTR_RST, 7'd0, 5'd0}},
		'{tcw_pkg::REQ_READ,  8'h00, 11'd2000, 1'b1, '{8'h00, 8'h00, 7'd0, 5'd0}},
		'{tcw_pkg::REQ_READ,  8'h00, 11'h7FF,  1'b1, '{8'h00, 8'h00, 7'd0, 5'd0}},
		'{tcw_pkg::REQ_PUT,   8'h41, 11'd0,    1'b1, '{8'h00, 8'h00, 7'd1, 5'd0}},
		'{tcw_pkg::REQ_PUT,   8'h00, 11'd0,    1'b1, '{8'h00, 8'h00, 7'd2, 5'd0}},
		'{tcw_pkg::REQ_PUT,   8'hFF, 11'd0,    1'b1, '{8'h00, 8'h00, 7'd3, 5'd0}},
		'{tcw_pkg::REQ_READ,  8'h00, 11'd2,    1'b1, '{8'hFF, ATTR_RST, 7'd3, 5'd0}},
		'{tcw_pkg::REQ_PUT,   CH_BS, 11'd0,    1'b1, '{8'h00, 8'h00, 7'd2, 5'd0}},
		'{tcw_pkg::REQ_READ,  8'h00, 11'd2,    1'b1, '{CH_SP, ATTR_RST, 7'd2, 5'd0}},
		'{tcw_pkg::REQ_PUT,   CH_NL, 11'd0,    1'b1, '{8'h00, 8'h00, 7'd0, 5'd1}},
		// backspace at column zero leaves everything alone
		'{tcw_pkg::REQ_PUT,   CH_BS, 11'd0,    1'b1, '{8'h00, 8'h00, 7'd0, 5'd1}},
		'{REQ_UNUSED,         8'h41, 11'h7FF,  1'b1, '{8'h00, 8'h00, 7'd0, 5'd1}},
		'{tcw_pkg::REQ_READ,  8'h00, 11'd0,    1'b1, '{8'h41, ATTR_RST, 7'd0, 5'd1}},
		'{tcw_pkg::REQ_PUT,   8'h09, 11'd0,    1'b0, '0},
		'{tcw_pkg::REQ_PUT,   8'h0B, 11'd0,    1'b0, '0},
		'{tcw_pkg::REQ_PUT,   8'h7F, 11'd0,    1'b0, '0},
		'{tcw_pkg::REQ_PUT,   8'h80, 11'd0,    1'b0, '0},
		'{tcw_pkg::REQ_READ,  8'h00, 11'd80,   1'b0, '0},
		'{tcw_pkg::REQ_READ,  8'h00, 11'd83,   1'b0, '0},
		'{tcw_pkg::REQ_CLEAR, 8'h00, 11'd0,    1'b1, '{8'h00, 8'h00, 7'd0, 5'd0}},
		'{tcw_pkg::REQ_READ,  8'h00, 11'd0,    1'b1, '{CH_SP, ATTR_RST, 7'd0, 5'd0}},
		'{tcw_pkg::REQ_READ,  8'h00, 11'd80,   1'b1, '{CH_SP, ATTR_RST, 7'd0, 5'd0}},
		'{tcw_pkg::REQ_READ,  8'h00, 11'd1024, 1'b0, '0}
	};

	logic clk;
	logic arst_n;

	tcw_req_if req_ch ();
	tcw_rsp_if rsp_ch ();
	tcw_cfg_if cfg_ch ();

	text_console_writer #(.COLUMNS(COLS), .ROWS(ROWS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// predicted screen and cursor
	tcw_pkg::cell_t screen_mem [CELLS];
	int             cur_col;
	int             cur_row;
	logic [7:0]     fill_attr;

	report_t       expected_reports [$];
	typed_report_t typed_reports [$];

	int errors;
	int items_sent;
	int read_count;
	int oor_read_count;
	int clear_count;
	int scroll_count;
	int report_count;
	int fill_writes;
	int gap_pct;
	int stall_pct;
	int quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void blank_cells(int first, int last);
		for (int i = first; i < last; i++)
			screen_mem[i] = '{attr: fill_attr, ch: CH_SP};
	endfunction

	function automatic report_t console_apply(logic [1:0] kind, logic [7:0] code,
		logic [10:0] idx);
		report_t r;
		r = '0;
		case (kind)
			tcw_pkg::REQ_PUT: begin
				if (code == CH_NL) begin
					cur_col = 0;
					cur_row++;
				end else if (code == CH_BS) begin
					if (cur_col > 0) begin
						cur_col--;
						screen_mem[cur_row * COLS + cur_col] = '{attr: fill_attr, ch: CH_SP};
					end
				end else begin
					screen_mem[cur_row * COLS + cur_col] = '{attr: fill_attr, ch: code};
					cur_col++;
				end
				if (cur_col >= COLS) begin
					cur_col = 0;
					cur_row++;
				end
				if (cur_row >= ROWS) begin
					for (int i = 0; i < (ROWS - 1) * COLS; i++)
						screen_mem[i] = screen_mem[i + COLS];
					blank_cells((ROWS - 1) * COLS, CELLS);
					cur_row = ROWS - 1;
					cur_col = 0;
					scroll_count++;
				end
			end
			tcw_pkg::REQ_CLEAR: begin
				blank_cells(0, CELLS);
				cur_col = 0;
				cur_row = 0;
				clear_count++;
			end
			tcw_pkg::REQ_READ: begin
				read_count++;
				if (idx < CELLS) begin
					r.ch   = screen_mem[idx].ch;
					r.attr = screen_mem[idx].attr;
				end else begin
					oor_read_count++;
				end
			end
			default: ;
		endcase
		r.col = 7'(cur_col);
		r.row = 5'(cur_row);
		return r;
	endfunction

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// request transfer -> prediction, response transfer -> compare
	always @(posedge clk) begin : scoreboard
		report_t       want;
		typed_report_t t;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				fill_attr = cfg_ch.fill_attribute;
			if (req_ch.valid && req_ch.ready) begin
				want = console_apply(req_ch.req_type, req_ch.char_code, req_ch.cell_index);
				if (typed_reports.size() != 0) begin
					t = typed_reports.pop_front();
					if (t.given)
						want = t.rpt;
				end
				expected_reports.push_back(want);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				report_count++;
				if (expected_reports.size() == 0) begin
					$display("%0t: response with nothing expected, got char %0d attr %0d",
						$time, rsp_ch.read_char, rsp_ch.read_attribute);
					errors++;
				end else begin
					want = expected_reports.pop_front();
					check_field("read_char", want.ch, rsp_ch.read_char);
					check_field("read_attribute", want.attr, rsp_ch.read_attribute);
					check_field("cursor_column", want.col, rsp_ch.cursor_column);
					check_field("cursor_row", want.row, rsp_ch.cursor_row);
				end
			end
		end
	end

	always @(posedge clk)
		rsp_ch.ready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_request(logic [1:0] kind, logic [7:0] code, logic [10:0] idx,
		logic given = 1'b0, report_t rpt = '0);
		while ($urandom_range(99) < gap_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		typed_reports.push_back('{given: given, rpt: rpt});
		req_ch.valid      <= 1'b1;
		req_ch.req_type   <= kind;
		req_ch.char_code  <= code;
		req_ch.cell_index <= idx;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic write_fill(logic [7:0] value);
		cfg_ch.valid          <= 1'b1;
		cfg_ch.fill_attribute <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		fill_writes++;
	endtask

	task automatic drain(int settle);
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	function automatic logic [10:0] pick_read_index();
		int p;
		p = $urandom_range(99);
		if (p < 40)
			return 11'(cur_row * COLS + $urandom_range(COLS - 1));
		else if (p < 55)
			return 11'((ROWS - 1) * COLS + $urandom_range(COLS - 1));
		else if (p < 65)
			return 11'($urandom_range(2047, CELLS));
		return 11'($urandom_range(CELLS - 1));
	endfunction

	// mostly lines of text ended by newline, plus newline runs, read bursts and odd single requests
	task automatic random_burst();
		int         pick;
		int         len;
		logic [7:0] c;
		pick = $urandom_range(99);
		if (pick < 50) begin
			len = ($urandom_range(99) < 85) ? $urandom_range(8) : $urandom_range(85, 60);
			for (int i = 0; i < len; i++) begin
				c = ($urandom_range(9) == 0) ? CH_BS : 8'($urandom_range(255));
				send_request(tcw_pkg::REQ_PUT, c, 11'($urandom_range(2047)));
			end
			if ($urandom_range(99) < 80)
				send_request(tcw_pkg::REQ_PUT, CH_NL, 11'($urandom_range(2047)));
		end else if (pick < 60) begin
			len = $urandom_range(6, 1);
			for (int i = 0; i < len; i++)
				send_request(tcw_pkg::REQ_PUT, CH_NL, 11'($urandom_range(2047)));
		end else if (pick < 85) begin
			len = $urandom_range(6, 1);
			for (int i = 0; i < len; i++)
				send_request(tcw_pkg::REQ_READ, 8'($urandom_range(255)), pick_read_index());
		end else begin
			pick = $urandom_range(99);
			if (pick < 10)
				send_request(tcw_pkg::REQ_CLEAR, 8'($urandom_range(255)),
					11'($urandom_range(2047)));
			else if (pick < 25)
				send_request(REQ_UNUSED, 8'($urandom_range(255)), 11'($urandom_range(2047)));
			else if (pick < 50)
				send_request(tcw_pkg::REQ_PUT, CH_BS, 11'($urandom_range(2047)));
			else if (pick < 75)
				send_request(tcw_pkg::REQ_PUT, 8'($urandom_range(255)),
					11'($urandom_range(2047)));
			else
				send_request(tcw_pkg::REQ_READ, 8'($urandom_range(255)),
					11'($urandom_range(2047)));
		end
	endtask

	initial begin : stimulus
		int         phase_gap [PHASES];
		int         phase_stall [PHASES];
		logic [7:0] phase_fill [PHASES];
		int         phase_end;
		phase_gap   = '{0, 48, 0, 32, 0};
		phase_stall = '{0, 0, 48, 32, 0};
		phase_fill  = '{8'h00, 8'hFF, 8'($urandom_range(254, 1)),
			8'($urandom_range(254, 1)), 8'h80};

		errors = 0;
		items_sent = 0;
		read_count = 0;
		oor_read_count = 0;
		clear_count = 0;
		scroll_count = 0;
		report_count = 0;
		fill_writes = 0;
		gap_pct = 0;
		stall_pct = 0;
		cur_col = 0;
		cur_row = 0;
		fill_attr = ATTR_RST;
		for (int i = 0; i < CELLS; i++)
			screen_mem[i] = '{attr: ATTR_RST, ch: CH_SP};

		arst_n                <= 1'b0;
		req_ch.valid          <= 1'b0;
		req_ch.req_type       <= tcw_pkg::REQ_PUT;
		req_ch.char_code      <= 8'h00;
		req_ch.cell_index     <= 11'd0;
		cfg_ch.valid          <= 1'b0;
		cfg_ch.fill_attribute <= 8'h00;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows run with the reset fill attribute
		for (int i = 0; i < N_DIRECTED; i++)
			send_request(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].code, DIRECTED_ROWS[i].idx,
				DIRECTED_ROWS[i].given, DIRECTED_ROWS[i].rpt);
		drain(8);

		for (int p = 0; p < PHASES; p++) begin
			write_fill(phase_fill[p]);
			@(posedge clk);
			gap_pct   = phase_gap[p];
			stall_pct = phase_stall[p];
			phase_end = items_sent + ITEMS_PER_PHASE;
			while (items_sent < phase_end)
				random_burst();
			drain(8);
			stall_pct = 0;
		end

		drain(20);
		if (expected_reports.size() != 0) begin
			$display("%0t: %0d expected responses never arrived", $time,
				expected_reports.size());
			errors++;
		end

		$display("%0d requests, %0d responses: %0d reads (%0d past the screen)",
			items_sent, report_count, read_count, oor_read_count);
		$display("%0d clears, %0d scrolls, %0d fill writes, idle sender/receiver/both; %0d errors",
			clear_count, scroll_count, fill_writes, errors);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: text_console_writer.f
+incdir+sv
sv/tcw_pkg.sv
sv/tcw_channels.sv
sv/tcw_screen_ram.sv
sv/tcw_ctrl.sv
sv/text_console_writer.sv
verif/tb_text_console_writer.sv
